// ----- hdl/psba_pkg.sv -----
// Shared types and constants for the partial-sum bias accumulator.
`default_nettype none

package psba_pkg;

    localparam int LANES      = 4;
    localparam int DATA_W     = 32;

    localparam int CFG_DATA_W  = 21;
    localparam int CFG_INDEX_W = 2;

    localparam int PIXEL_CFG_W = 21;
    localparam int ITER_CFG_W  = 9;
    localparam int GROUP_CFG_W = 7;

    localparam int PIXEL_MAX = 1048576;
    localparam int PIXEL_W   = 20;

    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COUNT      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_ITERATIONS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_GROUPS    = 2'd2;

    // Per-cycle controls from the sequencer to every lane
    typedef struct packed {
        logic load;     // item taken into the lane's stage register
        logic advance;  // stage item completes: store the new partial sum
        logic first;    // first input iteration: start from the bias
        logic forward;  // previous item wrote this group while we read it
    } lane_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/psba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module psba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/psba_lane.sv -----
// One accumulation lane: partial-sum store, start select and adder.
`default_nettype none

module psba_lane
    import psba_pkg::*;
#(
    parameter int MAX_GROUPS = 64
) (
    input  wire logic                clk,
    input  wire lane_ctl_t           ctl,
    input  wire logic [(MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1)-1:0] rd_addr,
    input  wire logic [(MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]   product,
    input  wire logic [DATA_W-1:0]   bias,
    output logic      [DATA_W-1:0]   sum
);

    logic [DATA_W-1:0] product_reg;
    logic [DATA_W-1:0] bias_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic [DATA_W-1:0] rd_data;
    logic [DATA_W-1:0] start;

    psba_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_GROUPS)
    ) u_partial (
        .clk   (clk),
        .we    (ctl.advance),
        .waddr (wr_addr),
        .wdata (sum),
        .re    (ctl.load),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            product_reg  <= product;
            bias_reg     <= bias;
            fwd_data_reg <= sum;   // sum being written this cycle, if any
        end
    end

    always_comb
    begin
        if (ctl.first)
        begin
            start = bias_reg;
        end
        else if (ctl.forward)
        begin
            start = fwd_data_reg;
        end
        else
        begin
            start = rd_data;
        end
    end

    assign sum = start + product_reg;  // wraps

endmodule

`default_nettype wire

// ----- hdl/psba_ctrl.sv -----
// Sequencer: configuration, group/iteration/pixel counters, stage handshake.
`default_nettype none

module psba_ctrl
    import psba_pkg::*;
#(
    parameter int MAX_GROUPS     = 64,
    parameter int MAX_ITERATIONS = 256
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   out_free,
    output lane_ctl_t                   lane_ctl,
    output logic [(MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1)-1:0] rd_addr,
    output logic [(MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1)-1:0] wr_addr,
    output logic                        emit,
    output logic                        emit_frame_last
);

    localparam int GROUP_W = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;
    localparam int ITER_W  = MAX_ITERATIONS > 1 ? $clog2(MAX_ITERATIONS) : 1;

    // configuration, held as last index (count - 1)
    logic [PIXEL_W-1:0] pixel_last_reg, pixel_last_next;
    logic [ITER_W-1:0]  iter_last_reg,  iter_last_next;
    logic [GROUP_W-1:0] group_last_reg, group_last_next;

    logic [PIXEL_W-1:0] pixel_reg, pixel_next;
    logic [ITER_W-1:0]  iter_reg,  iter_next;
    logic [GROUP_W-1:0] group_reg, group_next;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_first_reg;
    logic               s1_fwd_reg;
    logic               s1_emit_reg;
    logic               s1_frame_last_reg;
    logic [GROUP_W-1:0] s1_grp_reg;

    logic accept;
    logic s1_go;
    logic last_group;
    logic last_iter;
    logic last_pixel;

    logic [PIXEL_CFG_W-1:0] pix_v;
    logic [ITER_CFG_W-1:0]  iter_v;
    logic [GROUP_CFG_W-1:0] grp_v;

    assign pix_v  = cfg_data[PIXEL_CFG_W-1:0];
    assign iter_v = cfg_data[ITER_CFG_W-1:0];
    assign grp_v  = cfg_data[GROUP_CFG_W-1:0];

    // zero counts as one, values above range saturate
    always_comb
    begin
        pixel_last_next = pixel_last_reg;
        iter_last_next  = iter_last_reg;
        group_last_next = group_last_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PIXEL_COUNT:
                begin
                    if (pix_v == '0)
                        pixel_last_next = '0;
                    else if (32'(pix_v) > 32'(PIXEL_MAX))
                        pixel_last_next = PIXEL_W'(PIXEL_MAX - 1);
                    else
                        pixel_last_next = PIXEL_W'(pix_v - 1'b1);
                end
                REG_INPUT_ITERATIONS:
                begin
                    if (iter_v == '0)
                        iter_last_next = '0;
                    else if (32'(iter_v) > 32'(MAX_ITERATIONS))
                        iter_last_next = ITER_W'(MAX_ITERATIONS - 1);
                    else
                        iter_last_next = ITER_W'(iter_v - 1'b1);
                end
                REG_OUTPUT_GROUPS:
                begin
                    if (grp_v == '0)
                        group_last_next = '0;
                    else if (32'(grp_v) > 32'(MAX_GROUPS))
                        group_last_next = GROUP_W'(MAX_GROUPS - 1);
                    else
                        group_last_next = GROUP_W'(grp_v - 1'b1);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign last_group = group_reg >= group_last_reg;
    assign last_iter  = iter_reg  >= iter_last_reg;
    assign last_pixel = pixel_reg >= pixel_last_reg;

    assign s1_go    = s1_valid_reg && (!s1_emit_reg || out_free);
    assign in_ready = !s1_valid_reg || s1_go;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        group_next = group_reg;
        iter_next  = iter_reg;
        pixel_next = pixel_reg;
        if (accept)
        begin
            if (last_group)
            begin
                group_next = '0;
                if (last_iter)
                begin
                    iter_next  = '0;
                    pixel_next = last_pixel ? '0 : pixel_reg + 1'b1;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            else
            begin
                group_next = group_reg + 1'b1;
            end
        end

        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_last_reg    <= '0;
            iter_last_reg     <= '0;
            group_last_reg    <= '0;
            pixel_reg         <= '0;
            iter_reg          <= '0;
            group_reg         <= '0;
            s1_valid_reg      <= 1'b0;
            s1_first_reg      <= 1'b0;
            s1_fwd_reg        <= 1'b0;
            s1_emit_reg       <= 1'b0;
            s1_frame_last_reg <= 1'b0;
            s1_grp_reg        <= '0;
        end
        else
        begin
            pixel_last_reg <= pixel_last_next;
            iter_last_reg  <= iter_last_next;
            group_last_reg <= group_last_next;
            pixel_reg      <= pixel_next;
            iter_reg       <= iter_next;
            group_reg      <= group_next;
            s1_valid_reg   <= s1_valid_next;
            if (accept)
            begin
                s1_first_reg      <= iter_reg == '0;
                // RAM read sees old data when the stage item writes the same group
                s1_fwd_reg        <= s1_go && (s1_grp_reg == group_reg);
                s1_emit_reg       <= last_iter;
                s1_frame_last_reg <= last_iter && last_group && last_pixel;
                s1_grp_reg        <= group_reg;
            end
        end
    end

    assign lane_ctl.load    = accept;
    assign lane_ctl.advance = s1_go;
    assign lane_ctl.first   = s1_first_reg;
    assign lane_ctl.forward = s1_fwd_reg;
    assign rd_addr          = group_reg;
    assign wr_addr          = s1_grp_reg;
    assign emit             = s1_go && s1_emit_reg;
    assign emit_frame_last  = s1_frame_last_reg;

    property p_ready_only_blocked_by_stage;
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_emit_reg && !out_free);
    endproperty
    a_ready_only_blocked_by_stage: assert property (p_ready_only_blocked_by_stage)
        else $error("input stalled without a blocked result in the stage");

    property p_group_steps;
        @(posedge clk) disable iff (!rst_n)
        (accept && !last_group && !cfg_wr_en) |=> group_reg == $past(group_reg) + 1'b1;
    endproperty
    a_group_steps: assert property (p_group_steps)
        else $error("group counter did not step on an accepted item");

    property p_forward_same_group;
        @(posedge clk) disable iff (!rst_n)
        accept && s1_go && (s1_grp_reg == group_reg) |=> s1_fwd_reg;
    endproperty
    a_forward_same_group: assert property (p_forward_same_group)
        else $error("same-group hazard not forwarded");

    property p_frame_last_emits;
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_frame_last_reg) |-> s1_emit_reg;
    endproperty
    a_frame_last_emits: assert property (p_frame_last_emits)
        else $error("frame end marked on an item without a result");

endmodule

`default_nettype wire

// ----- hdl/channel_partial_sum_bias_add.sv -----
// Top level: four accumulation lanes, sequencer and merged result register.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    product_lane0..3, bias_lane0..3
//  out       output     out_valid / out_ready  sum_lane0..3, frame_last
//  cfg       input      cfg_wr_en              cfg_index, cfg_data
//
//  One item per cycle while in_ready is high. The accepting edge starts the read
//  of the group's partial sum from each lane RAM; the add stage adds, and writes
//  back when it advances, loading a result, if the item has one, into the output
//  register. Reset clears counters and configuration (all counts one); the
//  partial-sum RAMs are not cleared. in_ready drops only while a finished result
//  waits on out_ready with another result-producing item in the add stage.
`default_nettype none

module channel_partial_sum_bias_add
    import psba_pkg::*;
#(
    parameter int MAX_GROUPS     = 64,
    parameter int MAX_ITERATIONS = 256
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [DATA_W-1:0] product_lane0,
    input  wire logic signed [DATA_W-1:0] product_lane1,
    input  wire logic signed [DATA_W-1:0] product_lane2,
    input  wire logic signed [DATA_W-1:0] product_lane3,
    input  wire logic signed [DATA_W-1:0] bias_lane0,
    input  wire logic signed [DATA_W-1:0] bias_lane1,
    input  wire logic signed [DATA_W-1:0] bias_lane2,
    input  wire logic signed [DATA_W-1:0] bias_lane3,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      sum_lane0,
    output logic signed [DATA_W-1:0]      sum_lane1,
    output logic signed [DATA_W-1:0]      sum_lane2,
    output logic signed [DATA_W-1:0]      sum_lane3,
    output logic                          frame_last
);

    localparam int GROUP_W = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;

    lane_ctl_t          lane_ctl;
    logic [GROUP_W-1:0] rd_addr;
    logic [GROUP_W-1:0] wr_addr;
    logic               emit;
    logic               emit_frame_last;
    logic               out_free;

    logic [DATA_W-1:0] product [LANES];
    logic [DATA_W-1:0] bias    [LANES];
    logic [DATA_W-1:0] sum     [LANES];

    logic [DATA_W-1:0] sum_reg [LANES];
    logic              out_valid_reg, out_valid_next;
    logic              frame_last_reg;

    assign product[0] = product_lane0;
    assign product[1] = product_lane1;
    assign product[2] = product_lane2;
    assign product[3] = product_lane3;
    assign bias[0]    = bias_lane0;
    assign bias[1]    = bias_lane1;
    assign bias[2]    = bias_lane2;
    assign bias[3]    = bias_lane3;

    psba_ctrl #(
        .MAX_GROUPS     (MAX_GROUPS),
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .out_free        (out_free),
        .lane_ctl        (lane_ctl),
        .rd_addr         (rd_addr),
        .wr_addr         (wr_addr),
        .emit            (emit),
        .emit_frame_last (emit_frame_last)
    );

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        psba_lane #(
            .MAX_GROUPS (MAX_GROUPS)
        ) u_lane (
            .clk     (clk),
            .ctl     (lane_ctl),
            .rd_addr (rd_addr),
            .wr_addr (wr_addr),
            .product (product[i]),
            .bias    (bias[i]),
            .sum     (sum[i])
        );
    end

    // merge the lane sums into one result item
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                sum_reg[i] <= sum[i];
            end
            frame_last_reg <= emit_frame_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sum_lane0  = $signed(sum_reg[0]);
    assign sum_lane1  = $signed(sum_reg[1]);
    assign sum_lane2  = $signed(sum_reg[2]);
    assign sum_lane3  = $signed(sum_reg[3]);
    assign frame_last = frame_last_reg;

endmodule

`default_nettype wire

// ----- verif/psba_sum_checker.sv -----
// Checker: predicts the channel sums from accepted items and compares every result.
module psba_sum_checker
    import psba_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [LANES-1:0][DATA_W-1:0]  products,
    input  wire logic [LANES-1:0][DATA_W-1:0]  biases,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [LANES-1:0][DATA_W-1:0]  sums,
    input  wire logic                          frame_last,
    output int                                 mismatches,
    output int                                 sums_due_count,
    output int                                 sums_seen
);

    localparam int ITER_TOP  = 256;
    localparam int GROUP_TOP = 64;

    typedef struct packed {
        logic [LANES-1:0][DATA_W-1:0] lane_sum;
        logic                         last;
    } channel_sums_t;

    logic [DATA_W-1:0] partial [LANES][GROUP_TOP];
    int group_at;
    int iter_at;
    int pixel_at;
    int pixels_cfg = 1;
    int iters_cfg  = 1;
    int groups_cfg = 1;
    channel_sums_t sums_due [$];

    // zero reads as one, anything past the top saturates
    function automatic int settle(input int raw, input int top);
        if (raw == 0)
            return 1;
        if (raw > top)
            return top;
        return raw;
    endfunction

    task automatic accumulate(input logic [LANES-1:0][DATA_W-1:0] prod,
                              input logic [LANES-1:0][DATA_W-1:0] bias);
        channel_sums_t r;
        bit last_iter;
        bit last_group;
        bit last_pixel;
        int g;
        g = (group_at < GROUP_TOP) ? group_at : GROUP_TOP - 1;
        last_iter  = iter_at >= iters_cfg - 1;
        last_group = group_at >= groups_cfg - 1;
        last_pixel = pixel_at >= pixels_cfg - 1;
        for (int l = 0; l < LANES; l++)
        begin
            r.lane_sum[l] = ((iter_at == 0) ? bias[l] : partial[l][g]) + prod[l];
            partial[l][g] = r.lane_sum[l];
        end
        r.last = last_group && last_pixel;
        // counters past a lowered limit count as being at it and wrap next step
        if (last_group)
        begin
            group_at = 0;
            if (last_iter)
            begin
                iter_at  = 0;
                pixel_at = last_pixel ? 0 : pixel_at + 1;
            end
            else
            begin
                iter_at++;
            end
        end
        else
        begin
            group_at++;
        end
        if (last_iter)
            sums_due.push_back(r);
    endtask

    task automatic check_result;
        channel_sums_t want;
        if (sums_due.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result, sums %h frame_last %b", $time, sums, frame_last);
        end
        else
        begin
            want = sums_due.pop_front();
            for (int l = 0; l < LANES; l++)
            begin
                if (sums[l] !== want.lane_sum[l])
                begin
                    mismatches++;
                    $display("%0t: sum_lane%0d expected %h, got %h",
                             $time, l, want.lane_sum[l], sums[l]);
                end
            end
            if (frame_last !== want.last)
            begin
                mismatches++;
                $display("%0t: frame_last expected %b, got %b", $time, want.last, frame_last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_at       = 0;
            iter_at        = 0;
            pixel_at       = 0;
            pixels_cfg     = 1;
            iters_cfg      = 1;
            groups_cfg     = 1;
            sums_due.delete();
            sums_due_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_PIXEL_COUNT:
                        pixels_cfg = settle(int'(cfg_data[PIXEL_CFG_W-1:0]), PIXEL_MAX);
                    REG_INPUT_ITERATIONS:
                        iters_cfg = settle(int'(cfg_data[ITER_CFG_W-1:0]), ITER_TOP);
                    REG_OUTPUT_GROUPS:
                        groups_cfg = settle(int'(cfg_data[GROUP_CFG_W-1:0]), GROUP_TOP);
                    default:
                        ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                check_result();
                sums_seen++;
            end
            if (in_valid && in_ready)
                accumulate(products, biases);
            sums_due_count = sums_due.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the accumulator test: clock, reset, item and register stimulus, verdict.
module testbench;
    import psba_pkg::*;

    localparam int CYCLE_LIMIT  = 750000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 210;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [LANES-1:0][DATA_W-1:0] prod_drv;
    logic [LANES-1:0][DATA_W-1:0] bias_drv;
    logic out_valid;
    logic out_ready;
    logic signed [DATA_W-1:0] sum_lane0;
    logic signed [DATA_W-1:0] sum_lane1;
    logic signed [DATA_W-1:0] sum_lane2;
    logic signed [DATA_W-1:0] sum_lane3;
    logic frame_last;

    int mismatches;
    int sums_due_count;
    int sums_seen;
    int cycles;
    bit sender_burst;

    channel_partial_sum_bias_add dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .product_lane0 (prod_drv[0]),
        .product_lane1 (prod_drv[1]),
        .product_lane2 (prod_drv[2]),
        .product_lane3 (prod_drv[3]),
        .bias_lane0    (bias_drv[0]),
        .bias_lane1    (bias_drv[1]),
        .bias_lane2    (bias_drv[2]),
        .bias_lane3    (bias_drv[3]),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sum_lane0     (sum_lane0),
        .sum_lane1     (sum_lane1),
        .sum_lane2     (sum_lane2),
        .sum_lane3     (sum_lane3),
        .frame_last    (frame_last)
    );

    psba_sum_checker sum_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .products       (prod_drv),
        .biases         (bias_drv),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sums           ({sum_lane3, sum_lane2, sum_lane1, sum_lane0}),
        .frame_last     (frame_last),
        .mismatches     (mismatches),
        .sums_due_count (sums_due_count),
        .sums_seen      (sums_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("channel_partial_sum_bias_add test failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 19))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '1;
            3: return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [LANES-1:0][DATA_W-1:0] rand_lanes();
        logic [LANES-1:0][DATA_W-1:0] v;
        for (int l = 0; l < LANES; l++)
            v[l] = rand_word();
        return v;
    endfunction

    // raw register value for a wanted setting: one may go in as zero, the top as overrange
    function automatic logic [CFG_DATA_W-1:0] reg_code(input int value, input int top,
                                                       input int width);
        if (value == 1 && $urandom_range(0, 2) == 0)
            return '0;
        if (value == top && $urandom_range(0, 1) == 0)
            return CFG_DATA_W'($urandom_range(top, (1 << width) - 1));
        return CFG_DATA_W'(value);
    endfunction

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(input logic [LANES-1:0][DATA_W-1:0] prod,
                             input logic [LANES-1:0][DATA_W-1:0] bias);
        int gap;
        gap = pick_gap(sender_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        prod_drv <= prod;
        bias_drv <= bias;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic settle_idle;
        in_valid <= 1'b0;
        do @(negedge clk); while (sums_due_count != 0);
        // items with no result may still be in the add stage
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] pixels,
                                 input logic [CFG_DATA_W-1:0] iters,
                                 input logic [CFG_DATA_W-1:0] groups);
        write_reg(REG_PIXEL_COUNT, pixels);
        write_reg(REG_INPUT_ITERATIONS, iters);
        write_reg(REG_OUTPUT_GROUPS, groups);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin : result_sink
        int stall;
        int span;
        int hold_at;
        bit steady;
        out_ready = 1'b0;
        stall     = 0;
        span      = 0;
        hold_at   = 20;
        steady    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                steady = ($urandom_range(0, 3) == 0);
                span   = $urandom_range(50, 200);
            end
            span--;
            // long hold-off so the block backs up and drops in_ready
            if (sums_seen >= hold_at)
            begin
                stall   = 80;
                hold_at = hold_at + 250;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!steady)
                    stall = pick_gap(1'b0);
            end
        end
    end

    initial
    begin : stimulus
        int pix_eff;
        int iter_eff;
        int grp_eff;
        int per_pixel;
        int count;
        int random_sent;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        prod_drv     = '0;
        bias_drv     = '0;
        sender_burst = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: every item is a whole frame, sum = bias + product
        send_item({LANES{32'h7FFF_FFFF}}, {LANES{32'h7FFF_FFFF}});
        send_item({LANES{32'h8000_0000}}, {LANES{32'h8000_0000}});
        send_item({LANES{32'hFFFF_FFFF}}, {LANES{32'h0000_0001}});
        send_item({LANES{32'h0000_0000}}, {LANES{32'h0000_0000}});
        send_item({32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'hFFFF_FFFF},
                  {32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF, 32'h8000_0000});
        send_item({32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF, 32'h8000_0000},
                  {32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'hFFFF_FFFF});

        // two pixels of two iterations over three groups; unused index must be ignored
        settle_idle();
        write_reg(REG_UNUSED, '1);
        load_settings(21'd2, 21'd2, 21'd3);
        repeat (12)
            send_item(rand_lanes(), rand_lanes());

        // zero in every register acts as one
        settle_idle();
        load_settings('0, '0, '0);
        repeat (2)
            send_item(rand_lanes(), rand_lanes());

        // overrange values saturate; this pass also writes every group entry
        settle_idle();
        load_settings(21'h1F_FFFF, 21'd1, 21'h7F);
        repeat (64)
            send_item(rand_lanes(), rand_lanes());

        // deepest iteration count; pixel counter already sits on the new last pixel
        settle_idle();
        load_settings(21'd2, 21'h1FF, 21'd1);
        repeat (256)
            send_item(rand_lanes(), rand_lanes());

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle_idle();
            sender_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                grp_eff  = 64;
                iter_eff = $urandom_range(1, 2);
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                grp_eff  = $urandom_range(1, 2);
                iter_eff = $urandom_range(20, 64);
            end
            else
            begin
                grp_eff  = $urandom_range(1, 8);
                iter_eff = $urandom_range(1, 6);
            end
            pix_eff = ($urandom_range(0, 19) == 0) ? PIXEL_MAX : $urandom_range(1, 4);
            load_settings(reg_code(pix_eff, PIXEL_MAX, PIXEL_CFG_W),
                          reg_code(iter_eff, 256, ITER_CFG_W),
                          reg_code(grp_eff, 64, GROUP_CFG_W));
            per_pixel = grp_eff * iter_eff;
            // mostly whole pixels; sometimes stop mid-pixel so the next settings land mid-frame
            if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, 2 * per_pixel);
            else
                count = per_pixel * ((per_pixel > 32) ? 1 : $urandom_range(1, 3));
            repeat (count)
                send_item(rand_lanes(), rand_lanes());
            random_sent = random_sent + count;
        end
        sender_burst = 1'b0;

        settle_idle();
        if (mismatches == 0 && sums_due_count == 0)
            $display("channel_partial_sum_bias_add test passed");
        else
            $display("channel_partial_sum_bias_add test failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/psba_pkg.sv
hdl/psba_ram.sv
hdl/psba_lane.sv
hdl/psba_ctrl.sv
hdl/channel_partial_sum_bias_add.sv
verif/psba_sum_checker.sv
verif/testbench.sv
